// ----- src/fpedc_pkg.sv -----
`default_nettype none
package fpedc_pkg;

  typedef enum logic [2:0] {
    MODE_TICK    = 3'd0,
    MODE_EXAMINE = 3'd1,
    MODE_DEPOSIT = 3'd2,
    MODE_STEP    = 3'd3,
    MODE_RUNSTOP = 3'd4,
    MODE_PC      = 3'd5
  } mode_t;

  localparam int unsigned NUM_BUTTONS = 4;
  localparam logic [2:0]  LAST_GROUP  = 3'd6;
  localparam logic [3:0]  NIBBLE_MASK = 4'h f;

  localparam logic [2:0] GRP_DATA_HI = 3'd0;
  localparam logic [2:0] GRP_DATA_LO = 3'd1;
  localparam logic [2:0] GRP_ADDR0   = 3'd2;
  localparam logic [2:0] GRP_STATUS  = 3'd3;
  localparam logic [2:0] GRP_ADDR1   = 3'd4;
  localparam logic [2:0] GRP_ADDR2   = 3'd5;
  localparam logic [2:0] GRP_ADDR3   = 3'd6;

  typedef struct packed {
    mode_t       mode;
    logic        press_ok;
    logic        shift;
    logic [15:0] switches;
    logic        cpu_waiting;
    logic [15:0] cpu_pc;
  } cmd_t;

endpackage
`default_nettype wire

// ----- src/fpedc_front.sv -----
`default_nettype none
module fpedc_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [39:0]       s_axis_tdata,
  input  wire logic [2:0]        s_axis_tuser,
  input  wire logic              q_full,
  output logic                   push,
  output fpedc_pkg::cmd_t        push_cmd
);

  logic [15:0] tick_count;
  logic [15:0] last_press [fpedc_pkg::NUM_BUTTONS];
  fpedc_pkg::mode_t mode;
  logic [1:0] btn;
  logic       is_button;
  logic       press_ok;

  assign mode          = fpedc_pkg::mode_t'(s_axis_tuser);
  assign s_axis_tready = !q_full;
  assign push          = s_axis_tvalid && !q_full;
  assign btn           = 2'(s_axis_tuser - 3'd1);
  assign is_button     = (mode == fpedc_pkg::MODE_EXAMINE) || (mode == fpedc_pkg::MODE_DEPOSIT) ||
                         (mode == fpedc_pkg::MODE_STEP) || (mode == fpedc_pkg::MODE_RUNSTOP);
  assign press_ok      = is_button && (last_press[btn] != tick_count);

  always_comb begin
    push_cmd.mode        = mode;
    push_cmd.press_ok    = press_ok;
    push_cmd.shift       = s_axis_tdata[0];
    push_cmd.switches    = s_axis_tdata[16:1];
    push_cmd.cpu_waiting = s_axis_tdata[17];
    push_cmd.cpu_pc      = s_axis_tdata[33:18];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
      for (int i = 0; i < fpedc_pkg::NUM_BUTTONS; i++) begin
        last_press[i] <= '0;
      end
    end else if (push) begin
      if (mode == fpedc_pkg::MODE_TICK) begin
        tick_count <= tick_count + 16'd1;
      end else if (press_ok) begin
        last_press[btn] <= tick_count;
      end
    end
  end

endmodule
`default_nettype wire

// ----- src/fpedc_queue.sv -----
`default_nettype none
module fpedc_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire fpedc_pkg::cmd_t  push_cmd,
  output logic                  full,
  input  wire logic             pop,
  output logic                  head_valid,
  output fpedc_pkg::cmd_t       head_cmd
);

  fpedc_pkg::cmd_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_cmd   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- src/fpedc_back.sv -----
`default_nettype none
module fpedc_back #(
  parameter int unsigned RAM_ADDR_BITS = 12
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             head_valid,
  input  wire fpedc_pkg::cmd_t  head_cmd,
  output logic                  pop,
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output logic [39:0]           m_axis_tdata,
  output logic [0:0]            m_axis_tuser
);

  localparam int unsigned RAM_WORDS = 1 << RAM_ADDR_BITS;

  typedef enum logic {ST_EXEC, ST_READ} state_t;

  state_t      state;
  logic [15:0] addr;
  logic [7:0]  data;
  logic        held;
  logic [2:0]  scan;

  logic [7:0]  mem [RAM_WORDS];
  logic [7:0]  ram_rd;

  logic        out_strobe;
  logic [2:0]  out_sel;
  logic [3:0]  out_val;
  logic [15:0] out_addr;
  logic [7:0]  out_data;
  logic        out_hold;
  logic        out_rst;
  logic        out_stp;
  logic        out_spc;

  logic [15:0] addr_next;
  logic [7:0]  data_next;
  logic        held_next;
  logic [2:0]  scan_next;
  logic        we;
  logic        go_read;
  logic        strobe;
  logic [2:0]  sel;
  logic [3:0]  val;
  logic [3:0]  nibble;
  logic        rst_req;
  logic        stp_req;
  logic        act;

  assign pop = (state == ST_EXEC) && head_valid && (!m_axis_tvalid || m_axis_tready);
  assign act = head_cmd.press_ok && held;

  always_comb begin
    case (scan)
      fpedc_pkg::GRP_DATA_HI: nibble = data[7:4];
      fpedc_pkg::GRP_DATA_LO: nibble = data[3:0];
      fpedc_pkg::GRP_ADDR0:   nibble = addr[3:0];
      fpedc_pkg::GRP_STATUS:  nibble = {held, head_cmd.cpu_waiting, 2'b00};
      fpedc_pkg::GRP_ADDR1:   nibble = addr[7:4];
      fpedc_pkg::GRP_ADDR2:   nibble = addr[11:8];
      fpedc_pkg::GRP_ADDR3:   nibble = addr[15:12];
      default:                nibble = 4'h0;
    endcase
  end

  always_comb begin
    addr_next = addr;
    data_next = data;
    held_next = held;
    scan_next = scan;
    we        = 1'b0;
    go_read   = 1'b0;
    strobe    = 1'b0;
    sel       = 3'd0;
    val       = 4'd0;
    rst_req   = 1'b0;
    stp_req   = 1'b0;
    case (head_cmd.mode)
      fpedc_pkg::MODE_TICK: begin
        strobe    = 1'b1;
        sel       = scan;
        val       = ~nibble & fpedc_pkg::NIBBLE_MASK;
        scan_next = (scan >= fpedc_pkg::LAST_GROUP) ? 3'd0 : scan + 3'd1;
      end
      fpedc_pkg::MODE_EXAMINE: begin
        if (act) begin
          addr_next = head_cmd.shift ? addr + 16'd1 : head_cmd.switches;
          go_read   = 1'b1;
        end
      end
      fpedc_pkg::MODE_DEPOSIT: begin
        if (act) begin
          addr_next = head_cmd.shift ? addr + 16'd1 : addr;
          data_next = head_cmd.switches[7:0];
          we        = 1'b1;
        end
      end
      fpedc_pkg::MODE_STEP: begin
        stp_req = act;
      end
      fpedc_pkg::MODE_RUNSTOP: begin
        if (head_cmd.press_ok) begin
          if (head_cmd.shift) begin
            rst_req   = 1'b1;
            held_next = 1'b1;
          end else begin
            held_next = !held;
          end
        end
      end
      fpedc_pkg::MODE_PC: begin
        addr_next = head_cmd.cpu_pc;
      end
      default: begin
        addr_next = addr;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop && we) begin
      mem[addr_next[RAM_ADDR_BITS-1:0]] <= data_next;
    end
    ram_rd <= mem[addr_next[RAM_ADDR_BITS-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_EXEC;
      m_axis_tvalid <= 1'b0;
      addr          <= '0;
      data          <= '0;
      held          <= 1'b1;
      scan          <= '0;
    end else begin
      case (state)
        ST_EXEC: begin
          if (m_axis_tvalid && m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
          end
          if (pop) begin
            addr <= addr_next;
            data <= data_next;
            held <= held_next;
            scan <= scan_next;
            if (go_read) begin
              state <= ST_READ;
            end else begin
              m_axis_tvalid <= 1'b1;
              out_strobe    <= strobe;
              out_sel       <= sel;
              out_val       <= val;
              out_addr      <= addr_next;
              out_data      <= data_next;
              out_hold      <= held_next;
              out_rst       <= rst_req;
              out_stp       <= stp_req;
              out_spc       <= 1'b0;
            end
          end
        end
        ST_READ: begin
          data          <= ram_rd;
          m_axis_tvalid <= 1'b1;
          out_strobe    <= 1'b0;
          out_sel       <= 3'd0;
          out_val       <= 4'd0;
          out_addr      <= addr;
          out_data      <= ram_rd;
          out_hold      <= held;
          out_rst       <= 1'b0;
          out_stp       <= 1'b0;
          out_spc       <= 1'b1;
          state         <= ST_EXEC;
        end
        default: begin
          state <= ST_EXEC;
        end
      endcase
    end
  end

  assign m_axis_tuser = out_strobe;
  assign m_axis_tdata = {5'd0, out_spc, out_stp, out_rst, out_hold, out_data, out_addr,
                         out_val, out_sel};

endmodule
`default_nettype wire

// ----- src/front_panel_examine_deposit_controller.sv -----
// Front-panel controller: one event per word in, one result word out. A word is
// done in ST_EXEC of the back end; a carried-out examine also passes ST_READ, as
// the byte RAM read is registered. A two-word queue sits between the debounce front
// end and the back end, so input is taken until it is full while a result waits
// on m_axis_tready. RAM contents are undefined until deposited.
`default_nettype none
module front_panel_examine_deposit_controller #(
  parameter int unsigned RAM_ADDR_BITS = 12
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // shift, switches, cpu_waiting, cpu_pc
  input  wire logic [2:0]  s_axis_tuser,  // mode
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,  // led_select, led_value, addr_bus, data_bus,
                                          // hold, reset_request, step_request, set_pc
  output logic [0:0]       m_axis_tuser   // led_strobe
);

  logic            q_full;
  logic            push;
  fpedc_pkg::cmd_t push_cmd;
  logic            pop;
  logic            head_valid;
  fpedc_pkg::cmd_t head_cmd;

  fpedc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_full        (q_full),
    .push          (push),
    .push_cmd      (push_cmd)
  );

  fpedc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  fpedc_back #(
    .RAM_ADDR_BITS (RAM_ADDR_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head_cmd      (head_cmd),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule
`default_nettype wire
